/* rtl/fcipi_pkg.sv */
package fcipi_pkg;

   localparam int NUM_MOTORS_DEFAULT = 4;
   localparam int GAIN_CHANNELS      = 4;

   localparam int MOTOR_W = 2;
   localparam int SPEED_W = 24;
   localparam int ERR_W   = 25;
   localparam int GAIN_W  = 18;
   localparam int PROD_W  = GAIN_W + ERR_W;
   localparam int SUM_W   = PROD_W + 2;
   localparam int FRAC_SHIFT = 11;
   localparam int INC_W   = SUM_W - FRAC_SHIFT;
   localparam int ACC_W   = 40;
   localparam int DRIVE_W = 15;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [DRIVE_W-1:0] DRIVE_FULL = 15'd25600;
   localparam logic [SUM_W-1:0]   ROUND_HALF = SUM_W'(1024);

   localparam logic signed [GAIN_W-1:0] GAIN_NOW_RESET [GAIN_CHANNELS] = '{
      18'sd30781, 18'sd32072, 18'sd32604, 18'sd32113
   };
   localparam logic signed [GAIN_W-1:0] GAIN_PREV_RESET [GAIN_CHANNELS] = '{
      -18'sd28221, -18'sd27709, -18'sd28058, -18'sd27607
   };

   typedef enum logic [2:0] {
      REG_GAIN_NOW_M0  = 3'd0,
      REG_GAIN_PREV_M0 = 3'd1,
      REG_GAIN_NOW_M1  = 3'd2,
      REG_GAIN_PREV_M1 = 3'd3,
      REG_GAIN_NOW_M2  = 3'd4,
      REG_GAIN_PREV_M2 = 3'd5,
      REG_GAIN_NOW_M3  = 3'd6,
      REG_GAIN_PREV_M3 = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [MOTOR_W-1:0]        motor;
      logic signed [SPEED_W-1:0] measured_speed;
      logic signed [SPEED_W-1:0] setpoint;
   } req_type;

   typedef struct packed {
      logic [MOTOR_W-1:0] motor_out;
      logic [DRIVE_W-1:0] drive;
   } rsp_type;

endpackage

/* rtl/four_channel_incremental_pi_core.sv */
// Incremental PI speed controller shared by up to four motors.
// Request channel (req_valid / req_stall / req_data): one speed sample per
// request, naming the motor, its measured speed and its setpoint (Q.8).
// Response channel (rsp_valid / rsp_stall / rsp_data): one response per
// request, in request order, carrying the motor number and the drive
// command clamped to 0..100 percent (0..25600, 8 fractional bits).
// CSR port: APB-style, eight 18-bit Q6.11 gains at byte address 4*i,
// writes complete in the access cycle, pready is tied high.
// Throughput: one request per cycle while rsp_stall is low, set by a
// four-stage pipeline around two state memories (previous error, read
// and written at the request stage; accumulator, read entering stage 3
// and written leaving it, with a one-deep bypass for back-to-back
// requests on the same motor).
// Reset clears all valid flags and the per-motor valid bits at once, so
// every motor starts with zero error and zero accumulator; gains return
// to their default values. No clearing pass is needed.
// While rsp_stall is high the response holds in the output register and
// requests keep entering until the pipeline stages ahead of it fill up;
// req_stall then rises in the same cycle.
module four_channel_incremental_pi_core #(
   parameter int NUM_MOTORS = fcipi_pkg::NUM_MOTORS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  fcipi_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output fcipi_pkg::rsp_type                  rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fcipi_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [fcipi_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [fcipi_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);

   localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

   // ---------------------------------------------------------------
   // Gain registers
   // ---------------------------------------------------------------
   logic signed [fcipi_pkg::GAIN_W-1:0] gain_now_ff  [fcipi_pkg::GAIN_CHANNELS];
   logic signed [fcipi_pkg::GAIN_W-1:0] gain_prev_ff [fcipi_pkg::GAIN_CHANNELS];
   logic                                csr_write;
   fcipi_pkg::reg_index_type            csr_index;
   logic [fcipi_pkg::GAIN_W-1:0]        csr_value;
   logic signed [fcipi_pkg::GAIN_W-1:0] csr_rd_gain;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = fcipi_pkg::reg_index_type'(csr_paddr[4:2]);
   assign csr_value  = csr_pwdata[fcipi_pkg::GAIN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_now_ff  <= fcipi_pkg::GAIN_NOW_RESET;
         gain_prev_ff <= fcipi_pkg::GAIN_PREV_RESET;
      end else if (csr_write) begin
         case (csr_index)
            fcipi_pkg::REG_GAIN_NOW_M0:  gain_now_ff[0]  <= csr_value;
            fcipi_pkg::REG_GAIN_PREV_M0: gain_prev_ff[0] <= csr_value;
            fcipi_pkg::REG_GAIN_NOW_M1:  gain_now_ff[1]  <= csr_value;
            fcipi_pkg::REG_GAIN_PREV_M1: gain_prev_ff[1] <= csr_value;
            fcipi_pkg::REG_GAIN_NOW_M2:  gain_now_ff[2]  <= csr_value;
            fcipi_pkg::REG_GAIN_PREV_M2: gain_prev_ff[2] <= csr_value;
            fcipi_pkg::REG_GAIN_NOW_M3:  gain_now_ff[3]  <= csr_value;
            fcipi_pkg::REG_GAIN_PREV_M3: gain_prev_ff[3] <= csr_value;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         fcipi_pkg::REG_GAIN_NOW_M0:  csr_rd_gain = gain_now_ff[0];
         fcipi_pkg::REG_GAIN_PREV_M0: csr_rd_gain = gain_prev_ff[0];
         fcipi_pkg::REG_GAIN_NOW_M1:  csr_rd_gain = gain_now_ff[1];
         fcipi_pkg::REG_GAIN_PREV_M1: csr_rd_gain = gain_prev_ff[1];
         fcipi_pkg::REG_GAIN_NOW_M2:  csr_rd_gain = gain_now_ff[2];
         fcipi_pkg::REG_GAIN_PREV_M2: csr_rd_gain = gain_prev_ff[2];
         fcipi_pkg::REG_GAIN_NOW_M3:  csr_rd_gain = gain_now_ff[3];
         fcipi_pkg::REG_GAIN_PREV_M3: csr_rd_gain = gain_prev_ff[3];
         default:                     csr_rd_gain = '0;
      endcase
   end

   assign csr_prdata = {{(fcipi_pkg::CSR_DATA_W-fcipi_pkg::GAIN_W){1'b0}}, csr_rd_gain};

   // ---------------------------------------------------------------
   // Pipeline flow control (stages collapse bubbles independently)
   // ---------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, out_v_ff;
   logic v1_in, v2_in, v3_in, out_v_in;
   logic accept, en2, en3, move_out;

   assign move_out  = v3_ff & (~out_v_ff | ~rsp_stall);
   assign en3       = v2_ff & (~v3_ff | move_out);
   assign en2       = v1_ff & (~v2_ff | en3);
   assign req_stall = v1_ff & ~en2;
   assign accept    = req_valid & ~req_stall;

   assign v1_in    = accept   | (v1_ff & ~en2);
   assign v2_in    = en2      | (v2_ff & ~en3);
   assign v3_in    = en3      | (v3_ff & ~move_out);
   assign out_v_in = move_out | (out_v_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         v3_ff    <= v3_in;
         out_v_ff <= out_v_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: form the error, read and replace the previous error
   // ---------------------------------------------------------------
   logic                                 present_in;
   logic [IDX_W-1:0]                     req_idx;
   logic signed [fcipi_pkg::ERR_W-1:0]   err_in;

   assign present_in = int'(req_data.motor) < NUM_MOTORS;
   assign req_idx    = IDX_W'(req_data.motor);
   assign err_in     = fcipi_pkg::ERR_W'(req_data.setpoint)
                     - fcipi_pkg::ERR_W'(req_data.measured_speed);

   logic signed [fcipi_pkg::ERR_W-1:0]   prev_mem [NUM_MOTORS];
   logic [NUM_MOTORS-1:0]                prev_ok_ff;
   logic [fcipi_pkg::MOTOR_W-1:0]        motor1_ff;
   logic                                 present1_ff;
   logic signed [fcipi_pkg::ERR_W-1:0]   err1_ff;
   logic signed [fcipi_pkg::ERR_W-1:0]   prev1_ff;

   // The read sees the old entry even when this request overwrites it.
   always_ff @(posedge clock) begin
      if (accept) begin
         motor1_ff   <= req_data.motor;
         present1_ff <= present_in;
         err1_ff     <= err_in;
         if (present_in) begin
            prev1_ff          <= prev_ok_ff[req_idx] ? prev_mem[req_idx] : '0;
            prev_mem[req_idx] <= err_in;
         end else begin
            prev1_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ok_ff <= '0;
      end else if (accept && present_in) begin
         prev_ok_ff[req_idx] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: two products
   // ---------------------------------------------------------------
   logic signed [fcipi_pkg::GAIN_W-1:0] g_now, g_prev;
   logic signed [fcipi_pkg::PROD_W-1:0] p_now_in, p_prev_in;
   logic signed [fcipi_pkg::PROD_W-1:0] p_now2_ff, p_prev2_ff;
   logic [fcipi_pkg::MOTOR_W-1:0]       motor2_ff;
   logic                                present2_ff;

   assign g_now     = gain_now_ff[motor1_ff];
   assign g_prev    = gain_prev_ff[motor1_ff];
   assign p_now_in  = g_now * err1_ff;
   assign p_prev_in = g_prev * prev1_ff;

   always_ff @(posedge clock) begin
      if (en2) begin
         p_now2_ff   <= p_now_in;
         p_prev2_ff  <= p_prev_in;
         motor2_ff   <= motor1_ff;
         present2_ff <= present1_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: round the increment, read the accumulator
   // ---------------------------------------------------------------
   logic signed [fcipi_pkg::SUM_W-1:0] sum_in;
   logic signed [fcipi_pkg::INC_W-1:0] inc_in;
   logic [IDX_W-1:0]                   idx2;

   // Add half an LSB, then drop the low bits: floor, i.e. round half up.
   assign sum_in = fcipi_pkg::SUM_W'(p_now2_ff) + fcipi_pkg::SUM_W'(p_prev2_ff)
                 + fcipi_pkg::ROUND_HALF;
   assign inc_in = sum_in[fcipi_pkg::SUM_W-1:fcipi_pkg::FRAC_SHIFT];
   assign idx2   = IDX_W'(motor2_ff);

   logic signed [fcipi_pkg::ACC_W-1:0] acc_mem [NUM_MOTORS];
   logic [NUM_MOTORS-1:0]              acc_ok_ff;
   logic signed [fcipi_pkg::INC_W-1:0] inc3_ff;
   logic signed [fcipi_pkg::ACC_W-1:0] acc3_ff;
   logic signed [fcipi_pkg::ACC_W-1:0] acc_last_ff;
   logic [fcipi_pkg::MOTOR_W-1:0]      motor3_ff;
   logic                               present3_ff;
   logic                               fwd3_ff;
   logic [IDX_W-1:0]                   idx3;
   logic signed [fcipi_pkg::ACC_W-1:0] acc_old;
   logic signed [fcipi_pkg::ACC_W:0]   acc_sum;
   logic signed [fcipi_pkg::ACC_W-1:0] acc_new;
   logic [fcipi_pkg::DRIVE_W-1:0]      drive_in;
   logic                               acc_write;

   assign idx3      = IDX_W'(motor3_ff);
   assign acc_write = move_out & present3_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         inc3_ff     <= inc_in;
         motor3_ff   <= motor2_ff;
         present3_ff <= present2_ff;
         if (present2_ff) begin
            acc3_ff <= acc_ok_ff[idx2] ? acc_mem[idx2] : '0;
         end else begin
            acc3_ff <= '0;
         end
      end
      if (acc_write) begin
         acc_mem[idx3] <= acc_new;
         acc_last_ff   <= acc_new;
      end
   end

   // Bypass: the request ahead writes the same motor as this one reads.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd3_ff   <= 1'b0;
         acc_ok_ff <= '0;
      end else begin
         if (en3) begin
            fwd3_ff <= acc_write && (motor3_ff == motor2_ff);
         end
         if (acc_write) begin
            acc_ok_ff[idx3] <= 1'b1;
         end
      end
   end

   assign acc_old = fwd3_ff ? acc_last_ff : acc3_ff;
   assign acc_sum = (fcipi_pkg::ACC_W+1)'(acc_old) + (fcipi_pkg::ACC_W+1)'(inc3_ff);

   // Saturate at the 40-bit range.
   always_comb begin
      if (acc_sum[fcipi_pkg::ACC_W] != acc_sum[fcipi_pkg::ACC_W-1]) begin
         acc_new = acc_sum[fcipi_pkg::ACC_W]
                 ? {1'b1, {(fcipi_pkg::ACC_W-1){1'b0}}}
                 : {1'b0, {(fcipi_pkg::ACC_W-1){1'b1}}};
      end else begin
         acc_new = acc_sum[fcipi_pkg::ACC_W-1:0];
      end
   end

   // Clamp to 0..100 percent; a missing motor drives zero.
   always_comb begin
      if (!present3_ff || acc_new[fcipi_pkg::ACC_W-1]) begin
         drive_in = '0;
      end else if (acc_new > fcipi_pkg::ACC_W'(fcipi_pkg::DRIVE_FULL)) begin
         drive_in = fcipi_pkg::DRIVE_FULL;
      end else begin
         drive_in = acc_new[fcipi_pkg::DRIVE_W-1:0];
      end
   end

   // ---------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------
   fcipi_pkg::rsp_type rsp_q_ff;

   always_ff @(posedge clock) begin
      if (move_out) begin
         rsp_q_ff.motor_out <= motor3_ff;
         rsp_q_ff.drive     <= drive_in;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = rsp_q_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.drive <= fcipi_pkg::DRIVE_FULL)
      else $error("drive above full scale");

   a_missing_motor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (int'(rsp_data.motor_out) >= NUM_MOTORS) |-> rsp_data.drive == '0)
      else $error("missing motor produced nonzero drive");

   a_bypass_live: assert property (@(posedge clock) disable iff (reset)
      v3_ff && fwd3_ff |-> present3_ff)
      else $error("accumulator bypass without a live request");

   a_bypass_source: assert property (@(posedge clock) disable iff (reset)
      en3 && acc_write && (motor3_ff == motor2_ff) |=> fwd3_ff && acc_last_ff == $past(acc_new))
      else $error("accumulator bypass lost the previous update");

endmodule
